### sv/pvp_pkg.sv
// Package for the perspective vertex projection block.
// Shared widths, latency figures and the 32-bit saturate helper; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pvp_pkg;

  // numerator W*(w+x)+w: 17-bit by 33-bit product plus w
  localparam int NUM_W   = 51;
  // denominator 2*w, signed
  localparam int DEN_W   = 34;
  // divider: magnitude stage, one stage per quotient bit, output stage
  localparam int DIV_LAT = NUM_W + 2;
  // multiply, row sum, numerator, then divider
  localparam int PIPE_LAT = 3 + DIV_LAT;

  localparam int NREGS = 7;

  typedef enum logic [2:0] {
    REG_X_AB   = 3'd0,
    REG_X_CD   = 3'd1,
    REG_Y_AB   = 3'd2,
    REG_Y_CD   = 3'd3,
    REG_W_AB   = 3'd4,
    REG_W_CD   = 3'd5,
    REG_SCREEN = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] cw;
    logic               zero;
    logic               sx_neg;
    logic               sy_neg;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -67'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/perspective_vertex_projection.sv
// Perspective vertex projection top level: APB register file, clip-space
// multiply/sum stages and two pvp_div dividers. Depends on pvp_pkg, pvp_div.
//
// Usage: pulse start_i with pos_x_i/pos_y_i/pos_z_i; busy_o is always low, so
// a point is taken every cycle start_i is high. Each point gives one result
// beat on screen_x_o/screen_y_o/depth_w_o/divide_invalid_o, marked by a
// one-cycle valid_o, in the order the points were taken.
// Throughput is one point per cycle: the divider is fully pipelined, one
// quotient bit per stage (51 stages), behind a multiply stage (nine 32x32
// products), a row-sum/saturate stage and a numerator stage.
// The receiver cannot stall; results are never held.
// Registers sit at byte address 8*i over a 64-bit APB port; write them only
// while no point is in flight. Reset loads the identity-style matrix and a
// 1920x1080 viewport and clears all valid bits; data stages are not reset.
// When w is zero divide_invalid_o is set and the pixels saturate by the sign
// of W*x and -H*y.
`timescale 1ns / 1ps
`default_nettype none
module perspective_vertex_projection
  import pvp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  output logic                    valid_o,
  output logic signed [31:0]      screen_x_o,
  output logic signed [31:0]      screen_y_o,
  output logic signed [31:0]      depth_w_o,
  output logic                    divide_invalid_o
);

  logic [63:0] regs_q [0:NREGS-1];
  logic [2:0]  ridx;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign ridx   = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[REG_X_AB]   <= 64'd65536;
      regs_q[REG_X_CD]   <= 64'd0;
      regs_q[REG_Y_AB]   <= 64'd281474976710656;
      regs_q[REG_Y_CD]   <= 64'd0;
      regs_q[REG_W_AB]   <= 64'd0;
      regs_q[REG_W_CD]   <= 64'd281474976710656;
      regs_q[REG_SCREEN] <= 64'd70780800;
    end else if (wr_en) begin
      case (ridx)
        REG_X_AB, REG_X_CD, REG_Y_AB, REG_Y_CD, REG_W_AB, REG_W_CD: begin
          regs_q[ridx] <= pwdata;
        end
        REG_SCREEN: regs_q[REG_SCREEN] <= {32'd0, pwdata[31:0]};
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_X_AB, REG_X_CD, REG_Y_AB, REG_Y_CD, REG_W_AB, REG_W_CD, REG_SCREEN: begin
        prdata = regs_q[ridx];
      end
      default: prdata = '0;
    endcase
  end

  logic [15:0] scr_w, scr_h;
  assign scr_w = regs_q[REG_SCREEN][15:0];
  assign scr_h = regs_q[REG_SCREEN][31:16];

  // stage 1: nine products, rows x, y, w
  logic signed [63:0] prod_q [0:8];
  logic               v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      prod_q[3*r]   <= $signed(regs_q[2*r][31:0])    * pos_x_i;
      prod_q[3*r+1] <= $signed(regs_q[2*r][63:32])   * pos_y_i;
      prod_q[3*r+2] <= $signed(regs_q[2*r+1][31:0])  * pos_z_i;
    end
  end

  // stage 2: exact row sums, floor shift, offset, saturate
  logic signed [65:0] rsum [0:2];
  logic signed [66:0] rtot [0:2];
  logic signed [31:0] clip_q [0:2];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = 66'(prod_q[3*r]) + 66'(prod_q[3*r+1]) + 66'(prod_q[3*r+2]);
      rtot[r] = 67'(rsum[r] >>> FRAC_BITS) + 67'($signed(regs_q[2*r+1][63:32]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      clip_q[r] <= sat32(rtot[r]);
    end
  end

  // stage 3: numerators and denominator
  logic signed [32:0]      sum_x, dif_y;
  logic signed [49:0]      mul_x, mul_y;
  logic signed [NUM_W-1:0] numx_q, numy_q;
  logic signed [DEN_W-1:0] den_q;
  side_t                   side_d;
  side_t                   side_q [0:DIV_LAT];

  always_comb begin
    sum_x = 33'(clip_q[2]) + 33'(clip_q[0]);
    dif_y = 33'(clip_q[2]) - 33'(clip_q[1]);
    mul_x = $signed({1'b0, scr_w}) * sum_x;
    mul_y = $signed({1'b0, scr_h}) * dif_y;
    side_d.cw     = clip_q[2];
    side_d.zero   = (clip_q[2] == 32'sd0);
    side_d.sx_neg = (scr_w != 16'd0) && clip_q[0][31];
    side_d.sy_neg = (scr_h != 16'd0) && !clip_q[1][31] && (clip_q[1] != 32'sd0);
  end

  always_ff @(posedge clk_i) begin
    numx_q    <= NUM_W'(mul_x) + NUM_W'(clip_q[2]);
    numy_q    <= NUM_W'(mul_y) - NUM_W'(clip_q[2]);
    den_q     <= DEN_W'($signed({clip_q[2], 1'b0}));
    side_q[0] <= side_d;
    for (int k = 1; k <= DIV_LAT; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  logic signed [31:0] quo_x, quo_y;

  pvp_div u_div_x (.clk_i(clk_i), .num_i(numx_q), .den_i(den_q), .quo_o(quo_x));
  pvp_div u_div_y (.clk_i(clk_i), .num_i(numy_q), .den_i(den_q), .quo_o(quo_y));

  // valid bits: three front stages then the divider line
  logic [DIV_LAT-1:0] vline_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vline_q <= '0;
    end else begin
      v1_q    <= start_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      vline_q <= {vline_q[DIV_LAT-2:0], v3_q};
    end
  end

  side_t side_o;
  assign side_o = side_q[DIV_LAT];

  assign valid_o          = vline_q[DIV_LAT-1];
  assign depth_w_o        = side_o.cw;
  assign divide_invalid_o = side_o.zero;
  assign screen_x_o = side_o.zero ? (side_o.sx_neg ? 32'sh80000000 : 32'sh7fffffff) : quo_x;
  assign screen_y_o = side_o.zero ? (side_o.sy_neg ? 32'sh80000000 : 32'sh7fffffff) : quo_y;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(PIPE_LAT) valid_o) else $error("result beat missing");

  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && divide_invalid_o) |-> (depth_w_o == 32'sd0))
    else $error("invalid flag with nonzero depth");

  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && divide_invalid_o) |->
      ((screen_x_o == 32'sh80000000) || (screen_x_o == 32'sh7fffffff)))
    else $error("zero depth pixel not saturated");

endmodule
`default_nettype wire

### sv/pvp_div.sv
// Pipelined signed divider, one restoring step per stage, truncating quotient
// saturated to 32 bits. Depends on pvp_pkg for NUM_W, DEN_W.
`timescale 1ns / 1ps
`default_nettype none
module pvp_div
  import pvp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic signed [DEN_W-1:0] den_i,
  output logic signed [31:0]           quo_o
);

  logic [NUM_W-1:0] n_q   [0:NUM_W];
  logic [DEN_W-1:0] d_q   [0:NUM_W];
  logic [DEN_W-1:0] r_q   [0:NUM_W];
  logic [NUM_W-1:0] q_q   [0:NUM_W];
  logic             neg_q [0:NUM_W];

  logic [DEN_W:0]   rs    [1:NUM_W];
  logic [DEN_W-1:0] rn    [1:NUM_W];
  logic             qb    [1:NUM_W];
  logic signed [31:0] quo_d;
  logic signed [31:0] quo_q;

  always_comb begin
    for (int s = 1; s <= NUM_W; s++) begin
      rs[s] = {r_q[s-1], n_q[s-1][NUM_W-1]};
      qb[s] = (rs[s] >= {1'b0, d_q[s-1]});
      rn[s] = qb[s] ? DEN_W'(rs[s] - {1'b0, d_q[s-1]}) : DEN_W'(rs[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    n_q[0]   <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    d_q[0]   <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
    r_q[0]   <= '0;
    q_q[0]   <= '0;
    neg_q[0] <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    for (int s = 1; s <= NUM_W; s++) begin
      n_q[s]   <= {n_q[s-1][NUM_W-2:0], 1'b0};
      d_q[s]   <= d_q[s-1];
      r_q[s]   <= rn[s];
      q_q[s]   <= {q_q[s-1][NUM_W-2:0], qb[s]};
      neg_q[s] <= neg_q[s-1];
    end
  end

  always_comb begin
    if (neg_q[NUM_W]) begin
      if (q_q[NUM_W] > {{(NUM_W-32){1'b0}}, 32'h80000000}) begin
        quo_d = 32'sh80000000;
      end else begin
        quo_d = -$signed(q_q[NUM_W][31:0]);
      end
    end else begin
      if (q_q[NUM_W] > {{(NUM_W-32){1'b0}}, 32'h7fffffff}) begin
        quo_d = 32'sh7fffffff;
      end else begin
        quo_d = $signed(q_q[NUM_W][31:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule
`default_nettype wire
